>>> design/ecu_php_pkg.sv
package ecu_php_pkg;

  // Default width of the byte and payload counters
  localparam int CountWidth = 16;

  // Result queue depth; one accepted item pushes at most two results
  localparam int FifoDepth = 4;

  // Flags byte bits
  localparam int FlagLen     = 0;
  localparam int FlagNak     = 1;
  localparam int FlagSeq     = 2;
  localparam int FlagPartial = 3;
  localparam int FlagDone    = 4;

  // Result kinds
  localparam logic ItemByte    = 1'b0;
  localparam logic ItemSummary = 1'b1;

  // Status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatShort    = 2'd1;
  localparam logic [1:0] StatOverlong = 2'd2;

  // Packet classes
  localparam logic [3:0] ClsDatalog    = 4'd0;
  localparam logic [3:0] ClsInfoString = 4'd1;
  localparam logic [3:0] ClsIdList     = 4'd2;
  localparam logic [3:0] ClsIdInfo     = 4'd3;
  localparam logic [3:0] ClsVersion    = 4'd4;
  localparam logic [3:0] ClsFlash      = 4'd5;
  localparam logic [3:0] ClsRam        = 4'd6;
  localparam logic [3:0] ClsDescriptor = 4'd7;
  localparam logic [3:0] ClsBench      = 4'd8;
  localparam logic [3:0] ClsUnknown    = 4'd9;

  // Acknowledge kinds
  localparam logic [2:0] AckNak      = 3'd0;
  localparam logic [2:0] AckPartial  = 3'd1;
  localparam logic [2:0] AckComplete = 3'd2;
  localparam logic [2:0] AckPlain    = 3'd3;
  localparam logic [2:0] AckNone     = 3'd4;

  // Descriptor reassembly events
  localparam logic [1:0] EvNone      = 2'd0;
  localparam logic [1:0] EvStarted   = 2'd1;
  localparam logic [1:0] EvContinued = 2'd2;
  localparam logic [1:0] EvFinished  = 2'd3;

  // Fixed payload ids
  localparam logic [15:0] IdDatalog   = 16'h0191;
  localparam logic [15:0] IdInfoS0    = 16'hEEEF;
  localparam logic [15:0] IdInfoS1    = 16'hEEF1;
  localparam logic [15:0] IdInfoS2    = 16'hEEF3;
  localparam logic [15:0] IdInfoS3    = 16'hEEF5;
  localparam logic [15:0] IdInfoS4    = 16'hEEF7;
  localparam logic [15:0] IdInfoS5    = 16'hEEF9;
  localparam logic [15:0] IdIdList    = 16'hDA5F;
  localparam logic [15:0] IdIdInfo    = 16'hF8E1;
  localparam logic [15:0] IdIfVersion = 16'h0001;
  localparam logic [15:0] IdFwVersion = 16'h0003;
  localparam logic [15:0] IdFlash     = 16'h0107;
  localparam logic [15:0] IdRam       = 16'h0105;
  localparam logic [15:0] IdDescA     = 16'h0301;
  localparam logic [15:0] IdDescB     = 16'h030D;
  localparam logic [15:0] IdDescC     = 16'h030F;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_out;
    logic [1:0]  status;
    logic [15:0] payload_id;
    logic        is_nak;
    logic        has_length;
    logic [15:0] declared_length;
    logic [7:0]  partial_seq;
    logic [3:0]  packet_class;
    logic [2:0]  ack_kind;
    logic [15:0] nak_error;
    logic [1:0]  reassembly_event;
  } out_t;

  // Results produced by one accepted item: a forwarded byte, then a summary
  typedef struct packed {
    logic v0;
    out_t r0;
    logic v1;
    out_t r1;
  } push_t;

  // Id classification, first match wins
  function automatic logic [3:0] classify(input logic [15:0] id, input logic [15:0] bench_id);
    logic [3:0] cls;
    if (id == IdDatalog) begin
      cls = ClsDatalog;
    end else if (id == IdInfoS0 || id == IdInfoS1 || id == IdInfoS2 ||
                 id == IdInfoS3 || id == IdInfoS4 || id == IdInfoS5) begin
      cls = ClsInfoString;
    end else if (id == IdIdList) begin
      cls = ClsIdList;
    end else if (id == IdIdInfo) begin
      cls = ClsIdInfo;
    end else if (id == IdIfVersion || id == IdFwVersion) begin
      cls = ClsVersion;
    end else if (id == IdFlash) begin
      cls = ClsFlash;
    end else if (id == IdRam) begin
      cls = ClsRam;
    end else if (id == IdDescA || id == IdDescB || id == IdDescC) begin
      cls = ClsDescriptor;
    end else if (id == bench_id) begin
      cls = ClsBench;
    end else begin
      cls = ClsUnknown;
    end
    return cls;
  endfunction

endpackage

>>> design/ecu_php_parser.sv
module ecu_php_parser #(
  parameter int CountWidth = ecu_php_pkg::CountWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ecu_php_pkg::in_t    item_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  output ecu_php_pkg::push_t  push_o
);

  localparam int CmpW = (CountWidth > 16) ? CountWidth : 16;
  localparam logic [CountWidth-1:0] CntMax = {CountWidth{1'b1}};

  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [CountWidth-1:0] pay_cnt_q, pay_cnt_d;
  logic [7:0]            flags_q, flags_d;
  logic [15:0]           id_q, id_d;
  logic [15:0]           len_q, len_d;
  logic [7:0]            seq_q, seq_d;
  logic [7:0]            held_q, held_d;
  logic                  held_vld_q, held_vld_d;
  logic [15:0]           err_q, err_d;
  logic                  overlong_q, overlong_d;
  logic                  reasm_open_q, reasm_open_d;
  logic [15:0]           bench_id_q, bench_id_d;

  logic                  f_len, f_nak, f_seq, f_part, f_done;
  logic [3:0]            len_pos, part_pos, done_pos, pay_pos;
  logic [CmpW-1:0]       pay_ext, len_ext;
  logic [7:0]            b;
  logic [3:0]            cls;
  logic                  pkt_ok;
  ecu_php_pkg::out_t     byte_item, summ;

  assign b      = item_i.rx_byte;
  assign f_len  = flags_q[ecu_php_pkg::FlagLen];
  assign f_nak  = flags_q[ecu_php_pkg::FlagNak];
  assign f_seq  = flags_q[ecu_php_pkg::FlagSeq];
  assign f_part = flags_q[ecu_php_pkg::FlagPartial];
  assign f_done = flags_q[ecu_php_pkg::FlagDone];

  // Header field positions after the id
  assign len_pos  = 4'd3 + {3'b000, f_seq};
  assign part_pos = len_pos + {2'b00, f_len, 1'b0};
  assign done_pos = part_pos + {3'b000, f_part};
  assign pay_pos  = done_pos + {3'b000, f_done};

  assign pay_ext = CmpW'(pay_cnt_q);
  assign len_ext = CmpW'(len_q);

  // Forwarded byte result
  always_comb begin
    byte_item           = '0;
    byte_item.item_kind = ecu_php_pkg::ItemByte;
    byte_item.data_out  = held_q;
  end

  // Packet summary from the current packet state
  assign cls    = ecu_php_pkg::classify(id_q, bench_id_q);
  assign pkt_ok = (cnt_q >= CountWidth'(3)) && !overlong_q;

  always_comb begin
    summ                 = '0;
    summ.item_kind       = ecu_php_pkg::ItemSummary;
    summ.payload_id      = id_q;
    summ.is_nak          = f_nak;
    summ.has_length      = f_len;
    summ.declared_length = f_len ? len_q : 16'd0;
    summ.partial_seq     = seq_q;
    summ.packet_class    = cls;
    summ.ack_kind        = ecu_php_pkg::AckNone;
    summ.nak_error       = 16'd0;
    summ.reassembly_event = ecu_php_pkg::EvNone;
    if (cnt_q < CountWidth'(3)) begin
      summ.status = ecu_php_pkg::StatShort;
    end else if (overlong_q) begin
      summ.status = ecu_php_pkg::StatOverlong;
    end else begin
      summ.status = ecu_php_pkg::StatOk;
      if (cls != ecu_php_pkg::ClsDatalog) begin
        if (f_nak) begin
          summ.ack_kind = ecu_php_pkg::AckNak;
        end else if (f_part) begin
          summ.ack_kind = ecu_php_pkg::AckPartial;
        end else if (f_done) begin
          summ.ack_kind = ecu_php_pkg::AckComplete;
        end else begin
          summ.ack_kind = ecu_php_pkg::AckPlain;
        end
      end
      if (f_nak) begin
        summ.nak_error = err_q;
      end
      if (cls == ecu_php_pkg::ClsDescriptor) begin
        if (f_done) begin
          summ.reassembly_event = ecu_php_pkg::EvFinished;
        end else if (reasm_open_q) begin
          summ.reassembly_event = ecu_php_pkg::EvContinued;
        end else begin
          summ.reassembly_event = ecu_php_pkg::EvStarted;
        end
      end
    end
  end

  // Per-item state update and result generation
  always_comb begin
    cnt_d        = cnt_q;
    pay_cnt_d    = pay_cnt_q;
    flags_d      = flags_q;
    id_d         = id_q;
    len_d        = len_q;
    seq_d        = seq_q;
    held_d       = held_q;
    held_vld_d   = held_vld_q;
    err_d        = err_q;
    overlong_d   = overlong_q;
    reasm_open_d = reasm_open_q;
    push_o       = '0;
    push_o.r0    = byte_item;
    push_o.r1    = summ;
    if (accept_i) begin
      if (!item_i.last_byte) begin
        cnt_d = (cnt_q == CntMax) ? cnt_q : cnt_q + CountWidth'(1);
        if (cnt_q == CountWidth'(0)) begin
          flags_d = b;
        end else if (cnt_q == CountWidth'(1)) begin
          id_d = {b, id_q[7:0]};
        end else if (cnt_q == CountWidth'(2)) begin
          id_d = {id_q[15:8], b};
        end else if (f_len && cnt_q == CountWidth'(len_pos)) begin
          len_d = {b, len_q[7:0]};
        end else if (f_len && cnt_q == CountWidth'(len_pos + 4'd1)) begin
          len_d = {len_q[15:8], b};
        end else if (f_part && cnt_q == CountWidth'(part_pos)) begin
          seq_d = b;
        end else if (f_done && cnt_q == CountWidth'(done_pos)) begin
          seq_d = b;
        end else if (cnt_q >= CountWidth'(pay_pos)) begin
          if (f_len && pay_ext >= len_ext) begin
            overlong_d = 1'b1;
          end else begin
            if (pay_cnt_q == CountWidth'(0)) begin
              err_d = {b, err_q[7:0]};
            end else if (pay_cnt_q == CountWidth'(1)) begin
              err_d = {err_q[15:8], b};
            end
            push_o.v0  = held_vld_q;
            held_d     = b;
            held_vld_d = 1'b1;
            pay_cnt_d  = (pay_cnt_q == CntMax) ? pay_cnt_q : pay_cnt_q + CountWidth'(1);
          end
        end
      end else begin
        // Checksum byte: flush held byte, emit summary, start a new packet
        push_o.v0 = held_vld_q;
        push_o.v1 = 1'b1;
        if (pkt_ok && cls == ecu_php_pkg::ClsDescriptor) begin
          reasm_open_d = !f_done;
        end
        cnt_d      = '0;
        pay_cnt_d  = '0;
        flags_d    = '0;
        id_d       = '0;
        len_d      = '0;
        seq_d      = '0;
        held_d     = '0;
        held_vld_d = 1'b0;
        err_d      = '0;
        overlong_d = 1'b0;
      end
    end
  end

  // Bench reply id register
  assign bench_id_d = cfg_we_i ? cfg_wdata_i : bench_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pay_cnt_q    <= '0;
      flags_q      <= '0;
      id_q         <= '0;
      len_q        <= '0;
      seq_q        <= '0;
      held_q       <= '0;
      held_vld_q   <= 1'b0;
      err_q        <= '0;
      overlong_q   <= 1'b0;
      reasm_open_q <= 1'b0;
      bench_id_q   <= '0;
    end else begin
      cnt_q        <= cnt_d;
      pay_cnt_q    <= pay_cnt_d;
      flags_q      <= flags_d;
      id_q         <= id_d;
      len_q        <= len_d;
      seq_q        <= seq_d;
      held_q       <= held_d;
      held_vld_q   <= held_vld_d;
      err_q        <= err_d;
      overlong_q   <= overlong_d;
      reasm_open_q <= reasm_open_d;
      bench_id_q   <= bench_id_d;
    end
  end

endmodule

>>> design/ecu_php_fifo.sv
module ecu_php_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecu_php_pkg::push_t push_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ecu_php_pkg::out_t  out_item_o
);

  localparam int Depth = ecu_php_pkg::FifoDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  ecu_php_pkg::out_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr1;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  // Room for two results is needed before an item is taken
  assign full_o      = cnt_q > CntW'(Depth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Second result goes after the first when both are present
  assign wr_ptr1  = wr_ptr_q + PtrW'(push_i.v0);
  assign wr_ptr_d = wr_ptr1 + PtrW'(push_i.v1);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(push_i.v0) + CntW'(push_i.v1) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_ptr1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> design/ecu_packet_header_parser.sv
// Packet header parser for a deframed ECU serial link.
// Input channel: one packet byte per item (rx_byte, last_byte); the item
// with last_byte set is the checksum and closes the packet.
// Output channel: forwarded payload bytes (item_kind 0), each sent one byte
// late, and after the checksum a packet summary (item_kind 1) with status,
// id, class, acknowledge kind, NAK error and descriptor reassembly event.
// Config: cfg_we_i writes cfg_wdata_i into the bench reply id register;
// write it only while the block is idle.
// Timing: one input item per cycle while in_stall_o is low. Results are
// registered in a 4-entry result queue before they reach the output. The
// checksum item yields up to two results, drained one per cycle while
// out_stall_i is low; input stall rises with fewer than two entries free.
// Stalls: when out_stall_i is high the head result holds and the queue
// fills, which then stalls the input side.
// Reset: clears the packet state, the reassembly flag, the bench id and the
// result queue; the next byte is taken as a flags byte.
module ecu_packet_header_parser #(
  parameter int COUNT_WIDTH = ecu_php_pkg::CountWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ecu_php_pkg::in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ecu_php_pkg::out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  ecu_php_pkg::push_t push;
  logic               full;
  logic               accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Header decode and packet state
  ecu_php_parser #(
    .CountWidth (COUNT_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push)
  );

  // Result queue
  ecu_php_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
